### rtl/core/rsc_pkg.sv
// ----------------------------------------------------------------------------
// rsc_pkg
// Shared types and codes of the RPN stack calculator.
// ----------------------------------------------------------------------------
package rsc_pkg;

	localparam int unsigned DATA_W  = 32;
	localparam int unsigned CMD_W   = 4;
	localparam int unsigned IDX_W   = 10;
	localparam int unsigned STAT_W  = 3;
	localparam int unsigned DEPTH_W = 11;
	localparam int unsigned TDATA_W = 48;

	localparam logic [CMD_W-1:0] CMD_PUSH = 4'd0;
	localparam logic [CMD_W-1:0] CMD_ADD  = 4'd1;
	localparam logic [CMD_W-1:0] CMD_SUB  = 4'd2;
	localparam logic [CMD_W-1:0] CMD_MUL  = 4'd3;
	localparam logic [CMD_W-1:0] CMD_DIV  = 4'd4;
	localparam logic [CMD_W-1:0] CMD_REM  = 4'd5;
	localparam logic [CMD_W-1:0] CMD_POW  = 4'd6;
	localparam logic [CMD_W-1:0] CMD_INC  = 4'd7;
	localparam logic [CMD_W-1:0] CMD_DEC  = 4'd8;
	localparam logic [CMD_W-1:0] CMD_READ = 4'd9;

	localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
	localparam logic [STAT_W-1:0] ST_UNDER  = 3'd1;
	localparam logic [STAT_W-1:0] ST_OVER   = 3'd2;
	localparam logic [STAT_W-1:0] ST_ZDIV   = 3'd3;
	localparam logic [STAT_W-1:0] ST_BADIDX = 3'd4;

	typedef struct packed {
		logic             start;
		logic [CMD_W-1:0] op;
	} alu_req_t;

	typedef struct packed {
		logic              done;
		logic [STAT_W-1:0] status;
		logic [DATA_W-1:0] value;
	} alu_rsp_t;

endpackage

### rtl/core/rsc_stack_mem.sv
// ----------------------------------------------------------------------------
// rsc_stack_mem
// Stack storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rsc_stack_mem #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned AW    = 10
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [rsc_pkg::DATA_W-1:0] wdata,
	input  logic [AW-1:0]             raddr,
	output logic [rsc_pkg::DATA_W-1:0] rdata
);
	import rsc_pkg::*;

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/core/rsc_alu.sv
// ----------------------------------------------------------------------------
// rsc_alu
// Binary operation unit: add, sub and mul, bit-serial divide and
// remainder, power by repeated squaring.
// ----------------------------------------------------------------------------
module rsc_alu (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rsc_pkg::alu_req_t          req,
	input  logic [rsc_pkg::DATA_W-1:0] s_val,
	input  logic [rsc_pkg::DATA_W-1:0] t_val,
	output rsc_pkg::alu_rsp_t          rsp
);
	import rsc_pkg::*;

	typedef enum logic [2:0] {A_IDLE, A_DIV, A_FIX, A_POW, A_DONE} astate_t;

	astate_t           state_q;
	logic [STAT_W-1:0] stat_q;
	logic [DATA_W-1:0] res_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] dvs_q;
	logic [DATA_W-1:0] acc_q;
	logic [DATA_W-1:0] base_q;
	logic [DATA_W-1:0] ex_q;
	logic [4:0]        cnt_q;
	logic              is_div_q;
	logic              sn_q;
	logic              qneg_q;

	logic [DATA_W:0]   rem_sh;
	logic [DATA_W:0]   diff;
	logic [DATA_W-1:0] s_mag;
	logic [DATA_W-1:0] t_mag;

	assign s_mag  = s_val[DATA_W-1] ? (DATA_W'(0) - s_val) : s_val;
	assign t_mag  = t_val[DATA_W-1] ? (DATA_W'(0) - t_val) : t_val;
	assign rem_sh = {rem_q, quo_q[DATA_W-1]};
	assign diff   = rem_sh - {1'b0, dvs_q};

	assign rsp.done   = (state_q == A_DONE);
	assign rsp.status = stat_q;
	assign rsp.value  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
		end else begin
			unique case (state_q)
				A_IDLE: begin
					if (req.start) begin
						is_div_q <= (req.op == CMD_DIV);
						sn_q     <= s_val[DATA_W-1];
						qneg_q   <= s_val[DATA_W-1] ^ t_val[DATA_W-1];
						unique case (req.op)
							CMD_ADD: begin
								stat_q  <= ST_OK;
								res_q   <= s_val + t_val;
								state_q <= A_DONE;
							end
							CMD_SUB: begin
								stat_q  <= ST_OK;
								res_q   <= s_val - t_val;
								state_q <= A_DONE;
							end
							CMD_MUL: begin
								stat_q  <= ST_OK;
								res_q   <= s_val * t_val;
								state_q <= A_DONE;
							end
							CMD_DIV, CMD_REM: begin
								if (t_val == '0) begin
									stat_q  <= ST_ZDIV;
									res_q   <= '0;
									state_q <= A_DONE;
								end else begin
									stat_q  <= ST_OK;
									rem_q   <= '0;
									quo_q   <= s_mag;
									dvs_q   <= t_mag;
									cnt_q   <= '0;
									state_q <= A_DIV;
								end
							end
							default: begin
								if (!t_val[DATA_W-1]) begin
									stat_q  <= ST_OK;
									acc_q   <= DATA_W'(1);
									base_q  <= s_val;
									ex_q    <= t_val;
									state_q <= A_POW;
								end else if (s_val == '0) begin
									stat_q  <= ST_BADIDX;
									res_q   <= '0;
									state_q <= A_DONE;
								end else if (s_val == DATA_W'(1)) begin
									stat_q  <= ST_OK;
									res_q   <= DATA_W'(1);
									state_q <= A_DONE;
								end else if (s_val == '1) begin
									stat_q  <= ST_OK;
									res_q   <= t_val[0] ? '1 : DATA_W'(1);
									state_q <= A_DONE;
								end else begin
									stat_q  <= ST_OK;
									res_q   <= '0;
									state_q <= A_DONE;
								end
							end
						endcase
					end
				end
				A_DIV: begin
					if (!diff[DATA_W]) begin
						rem_q <= diff[DATA_W-1:0];
					end else begin
						rem_q <= rem_sh[DATA_W-1:0];
					end
					quo_q <= {quo_q[DATA_W-2:0], ~diff[DATA_W]};
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						state_q <= A_FIX;
					end
				end
				A_FIX: begin
					if (is_div_q) begin
						res_q <= qneg_q ? (DATA_W'(0) - quo_q) : quo_q;
					end else begin
						res_q <= sn_q ? (DATA_W'(0) - rem_q) : rem_q;
					end
					state_q <= A_DONE;
				end
				A_POW: begin
					if (ex_q == '0) begin
						res_q   <= acc_q;
						state_q <= A_DONE;
					end else begin
						if (ex_q[0]) begin
							acc_q <= acc_q * base_q;
						end
						base_q <= base_q * base_q;
						ex_q   <= ex_q >> 1;
					end
				end
				A_DONE: state_q <= A_IDLE;
				default: state_q <= A_IDLE;
			endcase
		end
	end

endmodule

### rtl/core/rpn_stack_calculator.sv
// ----------------------------------------------------------------------------
// rpn_stack_calculator
// Reverse Polish integer stack calculator over a synchronous stack memory.
// ----------------------------------------------------------------------------
// channel   dir  tdata fields (low bit up)
// s_axis    in   cmd[3:0] operand_value[35:4] read_index[45:36] zero[47:46]
// m_axis    out  status[2:0] result_value[34:3] stack_depth[45:35] zero[47:46]
//
// one word in, one word out, one word at a time
// push, early errors and other codes on an empty stack go straight to S_RESP;
// inc, dec, read, other codes: S_RD1, S_RESP; add, sub, mul, div, rem, pow: S_RD1, S_RD2, S_EXEC, S_RESP
// div, rem: S_EXEC waits on the bit-serial divider; pow: on the squaring loop
// memory read latency and the single read port set the operand fetch
// reset clears the depth count, the state and the output valid; stack entries are undefined until pushed
// a stalled result holds the block after the next word is taken
// ----------------------------------------------------------------------------
module rpn_stack_calculator #(
	parameter int unsigned STACK_DEPTH = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [rsc_pkg::TDATA_W-1:0] s_axis_tdata,  // cmd, operand_value, read_index
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [rsc_pkg::TDATA_W-1:0] m_axis_tdata   // status, result_value, stack_depth
);
	import rsc_pkg::*;

	localparam int unsigned AW = $clog2(STACK_DEPTH);
	localparam int unsigned DW = $clog2(STACK_DEPTH + 1);
	localparam logic [DW-1:0] FULL = DW'(STACK_DEPTH);

	typedef enum logic [2:0] {S_IDLE, S_RD1, S_RD2, S_EXEC, S_RESP} state_t;

	state_t            state_q;
	logic [DW-1:0]     depth_q;
	logic [CMD_W-1:0]  cmd_q;
	logic [DATA_W-1:0] t_q;
	logic [DATA_W-1:0] res_q;
	logic [STAT_W-1:0] stat_q;

	logic [CMD_W-1:0]  in_cmd;
	logic [DATA_W-1:0] in_opv;
	logic [IDX_W-1:0]  in_idx;
	logic              accept;
	logic [DW-1:0]     dm1;
	logic [DW-1:0]     dm2;
	logic [DATA_W-1:0] rdata;
	logic [DATA_W-1:0] incdec;
	logic              we;
	logic [AW-1:0]     waddr;
	logic [DATA_W-1:0] wdata;
	logic [AW-1:0]     raddr;
	alu_req_t          alu_req;
	alu_rsp_t          alu_rsp;

	assign in_cmd = s_axis_tdata[3:0];
	assign in_opv = s_axis_tdata[35:4];
	assign in_idx = s_axis_tdata[45:36];
	assign s_axis_tready = (state_q == S_IDLE);
	assign accept = s_axis_tvalid && s_axis_tready;
	assign dm1 = depth_q - DW'(1);
	assign dm2 = depth_q - DW'(2);
	assign incdec = (cmd_q == CMD_INC) ? (rdata + DATA_W'(1)) : (rdata - DATA_W'(1));

	assign alu_req.start = (state_q == S_RD2);
	assign alu_req.op    = cmd_q;

	// read address and write port
	always_comb begin
		raddr = dm1[AW-1:0];
		we    = 1'b0;
		waddr = depth_q[AW-1:0];
		wdata = in_opv;
		unique case (state_q)
			S_IDLE: begin
				if (in_cmd == CMD_READ) begin
					raddr = AW'(in_idx);
				end
				we = accept && (in_cmd == CMD_PUSH) && (depth_q < FULL);
			end
			S_RD1: begin
				raddr = dm2[AW-1:0];
				we    = (cmd_q == CMD_INC) || (cmd_q == CMD_DEC);
				waddr = dm1[AW-1:0];
				wdata = incdec;
			end
			S_EXEC: begin
				we    = alu_rsp.done && (alu_rsp.status == ST_OK);
				waddr = dm2[AW-1:0];
				wdata = alu_rsp.value;
			end
			default: ;
		endcase
	end

	rsc_stack_mem #(
		.DEPTH (STACK_DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	rsc_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.s_val  (rdata),
		.t_val  (t_q),
		.rsp    (alu_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			depth_q       <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready && state_q != S_RESP) begin
				m_axis_tvalid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q <= in_cmd;
						res_q <= (in_cmd == CMD_PUSH && depth_q < FULL) ? in_opv : '0;
						if (in_cmd == CMD_PUSH) begin
							state_q <= S_RESP;
							if (depth_q < FULL) begin
								stat_q  <= ST_OK;
								depth_q <= depth_q + DW'(1);
							end else begin
								stat_q <= ST_OVER;
							end
						end else if (in_cmd >= CMD_ADD && in_cmd <= CMD_POW) begin
							stat_q  <= (depth_q < DW'(2)) ? ST_UNDER : ST_OK;
							state_q <= (depth_q < DW'(2)) ? S_RESP : S_RD1;
						end else if (in_cmd == CMD_INC || in_cmd == CMD_DEC) begin
							stat_q  <= (depth_q == '0) ? ST_UNDER : ST_OK;
							state_q <= (depth_q == '0) ? S_RESP : S_RD1;
						end else if (in_cmd == CMD_READ) begin
							stat_q  <= (32'(in_idx) >= 32'(depth_q)) ? ST_BADIDX : ST_OK;
							state_q <= (32'(in_idx) >= 32'(depth_q)) ? S_RESP : S_RD1;
						end else begin
							stat_q  <= ST_OK;
							state_q <= (depth_q != '0) ? S_RD1 : S_RESP;
						end
					end
				end
				S_RD1: begin
					if (cmd_q >= CMD_ADD && cmd_q <= CMD_POW) begin
						t_q     <= rdata;
						state_q <= S_RD2;
					end else begin
						if (cmd_q == CMD_INC || cmd_q == CMD_DEC) begin
							res_q <= incdec;
						end else begin
							res_q <= rdata;
						end
						state_q <= S_RESP;
					end
				end
				S_RD2: state_q <= S_EXEC;
				S_EXEC: begin
					if (alu_rsp.done) begin
						stat_q <= alu_rsp.status;
						if (alu_rsp.status == ST_OK) begin
							res_q   <= alu_rsp.value;
							depth_q <= dm1;
						end
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (!m_axis_tvalid || m_axis_tready) begin
						m_axis_tvalid <= 1'b1;
						m_axis_tdata  <= {2'b00, DEPTH_W'(depth_q), res_q, stat_q};
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### rtl/core/rsc_checker.sv
// ----------------------------------------------------------------------------
// rsc_checker
// Port-level checks of the RPN stack calculator, bound to the top level.
// ----------------------------------------------------------------------------
module rsc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [47:0] s_axis_tdata,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [47:0] m_axis_tdata
);

	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output word changed under stall");

	// failed commands carry a zero value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[2:0] != 3'd0 |-> m_axis_tdata[34:3] == 32'd0)
		else $error("error word with nonzero value");

	// status code range and zero padding
	a_stat_rng: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[2:0] <= 3'd4 && m_axis_tdata[47:46] == 2'b00)
		else $error("bad status or padding");

	// one word at a time: busy right after a word is taken
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while busy");

endmodule

bind rpn_stack_calculator rsc_checker u_rsc_checker (.*);
